[sv/krt_pkg.sv]
// ----------------------------------------------------------------------------
// krt_pkg
// Shared types, widths, codes and helpers for the keyed record table.
// ----------------------------------------------------------------------------
package krt_pkg;

   // Default table capacity
   localparam int KRT_ENTRIES = 16;

   // Field widths
   localparam int KIND_W      = 2;
   localparam int STATUS_W    = 2;
   localparam int KEY_LOW_W   = 64;
   localparam int KEY_HIGH_W  = 16;
   localparam int VALUE_W     = 32;
   localparam int KEY_BYTES   = (KEY_LOW_W + KEY_HIGH_W) / 8;

   // Request kinds
   typedef enum logic [KIND_W-1:0] {
      KIND_INSERT = 2'd0,
      KIND_LOOKUP = 2'd1,
      KIND_REMOVE = 2'd2,
      KIND_UPDATE = 2'd3
   } kind_type;

   // Result status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_DUPLICATE = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   // Name key, zero padded after the terminator
   typedef struct packed {
      logic [KEY_HIGH_W-1:0] key_high;
      logic [KEY_LOW_W-1:0]  key_low;
   } key_type;

   // One table slot as stored in memory
   typedef struct packed {
      logic                valid;
      key_type             key;
      logic [VALUE_W-1:0]  value;
   } entry_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load_req;   // capture a new request word
      logic clear_wr;   // write an empty slot at the sweep address
      logic scan_rd;    // read the slot at the scan address
      logic cmp_en;     // compare the slot read in the previous cycle
      logic finish;     // apply the table write and load the result
   } krt_cmd_type;

   // Clear every byte that follows the first zero byte of the name
   function automatic key_type trim_key(input logic [KEY_LOW_W-1:0]  lo,
                                        input logic [KEY_HIGH_W-1:0] hi);
      logic [KEY_LOW_W+KEY_HIGH_W-1:0] w;
      logic                            ended;
      key_type                         k;
      w     = {hi, lo};
      ended = 1'b0;
      for (int i = 0; i < KEY_BYTES; i++) begin
         if (ended) begin
            w[8*i +: 8] = 8'h00;
         end else if (w[8*i +: 8] == 8'h00) begin
            ended = 1'b1;
         end
      end
      k.key_low  = w[KEY_LOW_W-1:0];
      k.key_high = w[KEY_LOW_W+KEY_HIGH_W-1:KEY_LOW_W];
      return k;
   endfunction

endpackage

[sv/krt_ifs.sv]
// ----------------------------------------------------------------------------
// krt_req_if / krt_rsp_if
// Valid/ready channels for request words and result words.
// ----------------------------------------------------------------------------
interface krt_req_if;
   import krt_pkg::*;

   logic                         valid;
   logic                         ready;
   logic [KIND_W-1:0]            kind;
   logic [KEY_LOW_W-1:0]         key_low;
   logic [KEY_HIGH_W-1:0]        key_high;
   logic signed [VALUE_W-1:0]    value_in;

   modport source (output valid, kind, key_low, key_high, value_in, input ready);
   modport sink   (input valid, kind, key_low, key_high, value_in, output ready);
endinterface

interface krt_rsp_if;
   import krt_pkg::*;

   logic                         valid;
   logic                         ready;
   logic [STATUS_W-1:0]          status;
   logic signed [VALUE_W-1:0]    value_out;

   modport source (output valid, status, value_out, input ready);
   modport sink   (input valid, status, value_out, output ready);
endinterface

[sv/krt_ctrl.sv]
// ----------------------------------------------------------------------------
// krt_ctrl
// Sequencer: clearing sweep after reset, slot scan per request, result
// hand-off into the output register.
// ----------------------------------------------------------------------------
module krt_ctrl #(
   parameter int  ENTRIES = krt_pkg::KRT_ENTRIES,
   localparam int AW      = $clog2(ENTRIES)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output krt_pkg::krt_cmd_type cmd,
   output logic [AW-1:0]        addr
);
   import krt_pkg::*;

   localparam logic [AW-1:0] LAST = AW'(ENTRIES - 1);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN,
      S_TAIL,
      S_FINISH
   } state_type;

   state_type     state_ff, state_in;
   logic [AW-1:0] cnt_ff, cnt_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // Next state and commands
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      addr         = cnt_ff;
      // drop the result once taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         S_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (cnt_ff == LAST) begin
               cnt_in   = '0;
               state_in = S_IDLE;
            end else begin
               cnt_in = AW'(cnt_ff + 1'b1);
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               cnt_in       = '0;
               state_in     = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan_rd = 1'b1;
            cmd.cmp_en  = (cnt_ff != '0);
            if (cnt_ff == LAST) begin
               cnt_in   = '0;
               state_in = S_TAIL;
            end else begin
               cnt_in = AW'(cnt_ff + 1'b1);
            end
         end
         S_TAIL: begin
            cmd.cmp_en = 1'b1;
            state_in   = S_FINISH;
         end
         S_FINISH: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // An accepted word starts a scan at the first slot
   a_accept_scan: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_SCAN && cnt_ff == '0))
      else $error("scan did not start after accept");

   // A result appears only after a finish step
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.finish))
      else $error("result without finish");

   // Finish only follows the tail compare or a stalled finish
   a_finish_order: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> ($past(state_ff) == S_TAIL || $past(state_ff) == S_FINISH))
      else $error("finish without complete scan");

endmodule

[sv/krt_dp.sv]
// ----------------------------------------------------------------------------
// krt_dp
// Datapath: slot memory, request word, key compare, hit and free-slot
// tracking, table write and result register.
// ----------------------------------------------------------------------------
module krt_dp #(
   parameter int  ENTRIES = krt_pkg::KRT_ENTRIES,
   localparam int AW      = $clog2(ENTRIES)
) (
   input  logic                                clock,
   input  logic                                reset,
   input  krt_pkg::krt_cmd_type                cmd,
   input  logic [AW-1:0]                       addr,
   input  logic [krt_pkg::KIND_W-1:0]          req_kind,
   input  logic [krt_pkg::KEY_LOW_W-1:0]       req_key_low,
   input  logic [krt_pkg::KEY_HIGH_W-1:0]      req_key_high,
   input  logic signed [krt_pkg::VALUE_W-1:0]  req_value_in,
   output logic [krt_pkg::STATUS_W-1:0]        rsp_status,
   output logic signed [krt_pkg::VALUE_W-1:0]  rsp_value_out
);
   import krt_pkg::*;

   // Slot memory
   entry_type          entry_mem_ff [ENTRIES];
   entry_type          rd_data_ff;
   logic [AW-1:0]      rd_addr_ff;

   // Request word
   kind_type           kind_ff;
   key_type            key_ff;
   logic [VALUE_W-1:0] val_ff;

   // Scan results
   logic               hit_ff;
   logic [AW-1:0]      hit_idx_ff;
   logic [VALUE_W-1:0] hit_val_ff;
   logic               free_ff;
   logic [AW-1:0]      free_idx_ff;

   // Result register
   status_type         status_ff;
   logic [VALUE_W-1:0] value_out_ff;

   logic               match;
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   entry_type          wr_data;
   status_type         status_in;
   logic [VALUE_W-1:0] value_out_in;
   logic               act_wr;
   logic [AW-1:0]      act_addr;
   entry_type          act_data;

   assign match = rd_data_ff.valid && (rd_data_ff.key == key_ff);

   // Decide the table write and the result for the scanned request
   always_comb begin
      status_in    = ST_OK;
      value_out_in = '0;
      act_wr       = 1'b0;
      act_addr     = hit_idx_ff;
      act_data.valid = 1'b1;
      act_data.key   = key_ff;
      act_data.value = val_ff;
      case (kind_ff)
         KIND_INSERT: begin
            if (hit_ff) begin
               status_in = ST_DUPLICATE;
            end else if (!free_ff) begin
               status_in = ST_FULL;
            end else begin
               act_wr   = 1'b1;
               act_addr = free_idx_ff;
            end
         end
         KIND_LOOKUP: begin
            if (hit_ff) begin
               value_out_in = hit_val_ff;
            end else begin
               status_in = ST_NOT_FOUND;
            end
         end
         KIND_REMOVE: begin
            if (hit_ff) begin
               act_wr         = 1'b1;
               act_data.valid = 1'b0;
            end else begin
               status_in = ST_NOT_FOUND;
            end
         end
         KIND_UPDATE: begin
            if (hit_ff) begin
               act_wr = 1'b1;
            end else begin
               status_in = ST_NOT_FOUND;
            end
         end
         default: begin
            status_in = ST_NOT_FOUND;
         end
      endcase
   end

   // Select between the clearing sweep and the request write
   always_comb begin
      wr_en   = cmd.clear_wr || (cmd.finish && act_wr);
      wr_addr = cmd.clear_wr ? addr : act_addr;
      wr_data = cmd.clear_wr ? entry_type'('0) : act_data;
   end

   // Write and read the slot memory
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem_ff[wr_addr] <= wr_data;
      end
      if (cmd.scan_rd) begin
         rd_data_ff <= entry_mem_ff[addr];
         rd_addr_ff <= addr;
      end
   end

   // Capture the request and track the scan
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         kind_ff <= kind_type'(req_kind);
         key_ff  <= trim_key(req_key_low, req_key_high);
         val_ff  <= req_value_in;
         hit_ff  <= 1'b0;
         free_ff <= 1'b0;
      end else if (cmd.cmp_en) begin
         if (match && !hit_ff) begin
            hit_ff     <= 1'b1;
            hit_idx_ff <= rd_addr_ff;
            hit_val_ff <= rd_data_ff.value;
         end
         if (!rd_data_ff.valid && !free_ff) begin
            free_ff     <= 1'b1;
            free_idx_ff <= rd_addr_ff;
         end
      end
   end

   // Load the result word
   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         status_ff    <= status_in;
         value_out_ff <= value_out_in;
      end
   end

   assign rsp_status    = status_ff;
   assign rsp_value_out = $signed(value_out_ff);

   // A duplicate insert leaves the table unchanged
   a_dup_no_write: assert property (@(posedge clock) disable iff (reset)
      (cmd.finish && kind_ff == KIND_INSERT && hit_ff) |-> !wr_en)
      else $error("duplicate insert wrote the table");

endmodule

[sv/keyed_record_table.sv]
// ----------------------------------------------------------------------------
// keyed_record_table
// Fixed-capacity table from a 10-byte name to a signed 32-bit number, with
// insert, lookup, remove and update requests and one result per request.
// ----------------------------------------------------------------------------
//  channel | direction | fields                                  | handshake
//  req     | in        | kind, key_low, key_high, value_in       | valid/ready
//  rsp     | out       | status, value_out                       | valid/ready
//
//  Each request runs from accept to the next accept through the accept
//  step, one memory read per slot in a linear scan, one compare tail and
//  one write or answer step, set by the single read port of the memory.
//  After reset a clearing sweep over every slot empties the table with
//  req.ready low. A waiting result does not block the next accept, but a
//  finished scan holds while the previous result is still not taken.
// ----------------------------------------------------------------------------
module keyed_record_table #(
   parameter int ENTRIES = krt_pkg::KRT_ENTRIES
) (
   input logic       clock,
   input logic       reset,
   krt_req_if.sink   req,
   krt_rsp_if.source rsp
);
   import krt_pkg::*;

   localparam int AW = $clog2(ENTRIES);

   krt_cmd_type   cmd;
   logic [AW-1:0] addr;

   krt_ctrl #(
      .ENTRIES (ENTRIES)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .cmd       (cmd),
      .addr      (addr)
   );

   krt_dp #(
      .ENTRIES (ENTRIES)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .addr          (addr),
      .req_kind      (req.kind),
      .req_key_low   (req.key_low),
      .req_key_high  (req.key_high),
      .req_value_in  (req.value_in),
      .rsp_status    (rsp.status),
      .rsp_value_out (rsp.value_out)
   );

endmodule
